FILE: hdl/gte_pkg.sv
// gte_pkg: shared types, widths and codes of the fixed-point matrix multiply engine.
// Used by gemm_transpose_engine_unit; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package gte_pkg;

    // Parameter defaults
    localparam int MAX_DIM_DEF     = 8;
    localparam int STORE_DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF  = 16;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int WOFF_W     = 8;
    localparam int WVAL_W     = 16;
    localparam int COFF_W     = 11;
    localparam int CVAL_W     = 35;
    localparam int FLAG_W     = 3;
    localparam int DIM_W      = 4;
    localparam int LEAD_W     = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    // Wide enough for any dim * lead + dim, and for the largest store depth
    localparam int OFF_W = 14;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // Action codes carried in tuser
    localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LAYOUT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_M = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS_N = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INNER  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LEAD_A = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEAD_B = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LEAD_C = 3'd6;

    // Layout flag bits
    localparam int FLAG_ROW_MAJOR = 0;
    localparam int FLAG_TRANS_A   = 1;
    localparam int FLAG_TRANS_B   = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } gte_state_t;

endpackage

`default_nettype wire

FILE: hdl/gemm_transpose_engine_unit.sv
// gemm_transpose_engine_unit: top level of the fixed-point matrix multiply engine.
// Depends on gte_pkg and gte_ram.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point GEMM engine. Input beats carry an action in tuser: load an A word, load a
// B word, or start a multiply. Loads write one word per cycle into the A or B store, while
// no start is in progress, and produce no output; an offset at or beyond STORE_DEPTH is
// dropped. A start beat computes C = op(A) x op(B) for the M x N x K set in the config
// registers and emits one output beat per C element, rows outer in row-major layout and
// columns outer in column-major, with tlast on the final element. Each element carries
// its linear C offset (wrapped to 11 bits), the exact Q19.16 sum and a flag in tuser set
// when any operand offset fell outside its store (that operand reads as zero). Dimension
// registers above MAX_DIM saturate; M or N of zero makes a start beat produce nothing. A
// start holds the input off until its last element is handed to the output register,
// including any output stall. A single shared multiply-accumulate unit steps through the
// k terms in turn (store read, multiply, accumulate), then closes the element and hands
// it to the output register. The output register lets the engine close the next element
// while a finished one waits. Store contents are undefined after reset until written;
// there is no clearing pass. Config writes take effect at once; issue them only while no
// start is in progress.

module gemm_transpose_engine_unit #(
    parameter int MAX_DIM     = gte_pkg::MAX_DIM_DEF,
    parameter int STORE_DEPTH = gte_pkg::STORE_DEPTH_DEF,
    parameter int DATA_WIDTH  = gte_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Config write port
    input  wire logic                               cfg_we,
    input  wire logic [gte_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [gte_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    // Input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: [7:0] word_offset, [23:8] word_value
    input  wire logic [gte_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: [1:0] action
    input  wire logic [gte_pkg::ACTION_W-1:0]       s_axis_tuser,

    // Output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: [10:0] c_offset, [45:11] c_value, [47:46] zero
    output logic      [gte_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: [0] bad_offset
    output logic      [0:0]                         m_axis_tuser,
    output logic                                    m_axis_tlast
);

    import gte_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [FLAG_W-1:0] flags_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [DIM_W-1:0]  inner_reg;
    logic [LEAD_W-1:0] lead_a_reg;
    logic [LEAD_W-1:0] lead_b_reg;
    logic [LEAD_W-1:0] lead_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= FLAG_W'(1);
            rows_reg   <= DIM_W'(8);
            cols_reg   <= DIM_W'(8);
            inner_reg  <= DIM_W'(8);
            lead_a_reg <= LEAD_W'(8);
            lead_b_reg <= LEAD_W'(8);
            lead_c_reg <= LEAD_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LAYOUT: flags_reg  <= cfg_wdata[FLAG_W-1:0];
                REG_ROWS_M: rows_reg   <= cfg_wdata[DIM_W-1:0];
                REG_COLS_N: cols_reg   <= cfg_wdata[DIM_W-1:0];
                REG_INNER:  inner_reg  <= cfg_wdata[DIM_W-1:0];
                REG_LEAD_A: lead_a_reg <= cfg_wdata[LEAD_W-1:0];
                REG_LEAD_B: lead_b_reg <= cfg_wdata[LEAD_W-1:0];
                REG_LEAD_C: lead_c_reg <= cfg_wdata[LEAD_W-1:0];
                default:    ;
            endcase
        end
    end

    // Saturate dimensions to MAX_DIM
    logic [DIM_W-1:0] dim_m;
    logic [DIM_W-1:0] dim_n;
    logic [DIM_W-1:0] dim_k;

    assign dim_m = (rows_reg  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_reg;
    assign dim_n = (cols_reg  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_reg;
    assign dim_k = (inner_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_reg;

    // ------------------------------------------------------------------
    // Input beat decode and store writes
    // ------------------------------------------------------------------
    logic [ACTION_W-1:0]   in_action;
    logic [WOFF_W-1:0]     in_offset;
    logic [WVAL_W-1:0]     in_value;
    logic                  in_fire;
    logic                  wr_in_range;
    logic                  a_we;
    logic                  b_we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;

    assign in_action   = s_axis_tuser;
    assign in_offset   = s_axis_tdata[WOFF_W-1:0];
    assign in_value    = s_axis_tdata[WOFF_W +: WVAL_W];
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign wr_in_range = OFF_W'(in_offset) < OFF_W'(STORE_DEPTH);
    assign a_we        = in_fire && (in_action == ACT_LOAD_A) && wr_in_range;
    assign b_we        = in_fire && (in_action == ACT_LOAD_B) && wr_in_range;
    assign waddr       = AW'(in_offset);
    assign wdata       = DATA_WIDTH'(in_value);

    // ------------------------------------------------------------------
    // Operand offsets for the current (i, j, k)
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;

    logic             trans_a;
    logic             trans_b;
    logic             row_major;
    logic [DIM_W-1:0] a_major;
    logic [DIM_W-1:0] a_minor;
    logic [DIM_W-1:0] b_major;
    logic [DIM_W-1:0] b_minor;
    logic [OFF_W-1:0] a_off;
    logic [OFF_W-1:0] b_off;
    logic [OFF_W-1:0] c_off;
    logic [AW-1:0]    a_raddr;
    logic [AW-1:0]    b_raddr;

    assign trans_a   = flags_reg[FLAG_TRANS_A];
    assign trans_b   = flags_reg[FLAG_TRANS_B];
    assign row_major = flags_reg[FLAG_ROW_MAJOR];

    // The layout bit cancels out of the operand offsets: only the transposes matter
    assign a_major = trans_a ? k_reg : i_reg;
    assign a_minor = trans_a ? i_reg : k_reg;
    assign b_major = trans_b ? j_reg : k_reg;
    assign b_minor = trans_b ? k_reg : j_reg;

    assign a_off = OFF_W'(a_major) * OFF_W'(lead_a_reg) + OFF_W'(a_minor);
    assign b_off = OFF_W'(b_major) * OFF_W'(lead_b_reg) + OFF_W'(b_minor);
    assign c_off = row_major ? OFF_W'(i_reg) * OFF_W'(lead_c_reg) + OFF_W'(j_reg)
                             : OFF_W'(j_reg) * OFF_W'(lead_c_reg) + OFF_W'(i_reg);

    assign a_raddr = a_off[AW-1:0];
    assign b_raddr = b_off[AW-1:0];

    // ------------------------------------------------------------------
    // Operand stores
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] a_rdata;
    logic [DATA_WIDTH-1:0] b_rdata;

    gte_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    gte_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer and shared multiply-accumulate
    // ------------------------------------------------------------------
    gte_state_t state_reg, state_next;

    logic                           a_oob_reg, a_oob_next;
    logic                           b_oob_reg, b_oob_next;
    logic                           bad_reg, bad_next;
    logic signed [2*DATA_WIDTH-1:0] prod_reg, prod_next;
    logic signed [CVAL_W-1:0]       acc_reg, acc_next;

    logic                           out_valid_reg, out_valid_next;
    logic [COFF_W-1:0]              out_coff_reg, out_coff_next;
    logic signed [CVAL_W-1:0]       out_cval_reg, out_cval_next;
    logic                           out_bad_reg, out_bad_next;
    logic                           out_last_reg, out_last_next;

    logic signed [DATA_WIDTH-1:0]   a_op;
    logic signed [DATA_WIDTH-1:0]   b_op;
    logic                           out_free;
    logic                           i_end;
    logic                           j_end;
    logic                           elem_last;

    // Out-of-range operands read as zero
    assign a_op = a_oob_reg ? '0 : signed'(a_rdata);
    assign b_op = b_oob_reg ? '0 : signed'(b_rdata);

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign i_end     = (i_reg == DIM_W'(dim_m - DIM_W'(1)));
    assign j_end     = (j_reg == DIM_W'(dim_n - DIM_W'(1)));
    assign elem_last = i_end && j_end;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            bad_reg       <= 1'b0;
            a_oob_reg     <= 1'b0;
            b_oob_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            bad_reg       <= bad_next;
            a_oob_reg     <= a_oob_next;
            b_oob_reg     <= b_oob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_coff_reg <= out_coff_next;
        out_cval_reg <= out_cval_next;
        out_bad_reg  <= out_bad_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        bad_next       = bad_reg;
        a_oob_next     = a_oob_reg;
        b_oob_next     = b_oob_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_coff_next  = out_coff_reg;
        out_cval_next  = out_cval_reg;
        out_bad_next   = out_bad_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Start a run unless the result is empty
                if (in_fire && (in_action == ACT_START) &&
                    (dim_m != '0) && (dim_n != '0))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    bad_next   = 1'b0;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                // Address goes to both stores this cycle; note range faults
                if (k_reg == dim_k)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    a_oob_next = a_off >= OFF_W'(STORE_DEPTH);
                    b_oob_next = b_off >= OFF_W'(STORE_DEPTH);
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next  = a_op * b_op;
                bad_next   = bad_reg || a_oob_reg || b_oob_reg;
                k_next     = DIM_W'(k_reg + DIM_W'(1));
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                acc_next   = acc_reg + CVAL_W'(prod_reg);
                state_next = ST_READ;
            end

            ST_EMIT:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_coff_next  = c_off[COFF_W-1:0];
                    out_cval_next  = acc_reg;
                    out_bad_next   = bad_reg;
                    out_last_next  = elem_last;
                    acc_next       = '0;
                    bad_next       = 1'b0;
                    k_next         = '0;
                    if (row_major)
                    begin
                        if (j_end)
                        begin
                            j_next = '0;
                            i_next = DIM_W'(i_reg + DIM_W'(1));
                        end
                        else
                        begin
                            j_next = DIM_W'(j_reg + DIM_W'(1));
                        end
                    end
                    else
                    begin
                        if (i_end)
                        begin
                            i_next = '0;
                            j_next = DIM_W'(j_reg + DIM_W'(1));
                        end
                        else
                        begin
                            i_next = DIM_W'(i_reg + DIM_W'(1));
                        end
                    end
                    state_next = elem_last ? ST_IDLE : ST_READ;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output beat
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - CVAL_W - COFF_W)'(0), out_cval_reg, out_coff_reg};
    assign m_axis_tuser  = out_bad_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/gte_ram.sv
// gte_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module gte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
